// File: design/shfp_pkg.sv
`default_nettype none

package shfp_pkg;

  // Configuration register reset values
  localparam logic [7:0] SYNC_RST   = 8'd250;
  localparam logic [7:0] GROUP_RST  = 8'd57;
  localparam logic [4:0] HDR_RST    = 5'd4;
  localparam logic [9:0] BODY_RST   = 10'd128;

  // Header count limits
  localparam logic [4:0] HDR_MIN    = 5'd2;
  localparam logic [4:0] HDR_MAX    = 5'd16;

  // Default largest body length
  localparam int unsigned MAX_BODY_DEF = 512;

  // Field widths
  localparam int unsigned HDR_W  = 5;
  localparam int unsigned BODY_W = 10;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned CNT_W  = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC  = 2'd0,
    CFG_GROUP = 2'd1,
    CFG_HDR   = 2'd2,
    CFG_BODY  = 2'd3
  } cfg_idx_t;

  // Settings shared with the parser
  typedef struct packed {
    logic [7:0]       sync_value;
    logic [7:0]       group_value;
    logic [HDR_W-1:0] eff_header;
  } shfp_cfg_t;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_SYNC   = 4'b0001,
    PH_GROUP  = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  // CRC-16-CCITT, one byte, table-free form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, d};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/shfp_cfg.sv
`default_nettype none

module shfp_cfg #(
  parameter int unsigned MAX_BODY = shfp_pkg::MAX_BODY_DEF,
  parameter int unsigned IDX_W    = $clog2(MAX_BODY + 2)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [9:0]            cfg_data,
  output shfp_pkg::shfp_cfg_t        cfg_o,
  output logic [IDX_W-1:0]           eff_body_o
);
  import shfp_pkg::*;

  localparam int unsigned CMP_W = (IDX_W > BODY_W) ? IDX_W : BODY_W;

  logic [7:0]        sync_r, sync_nxt;
  logic [7:0]        group_r, group_nxt;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [BODY_W-1:0] body_r, body_nxt;
  logic [HDR_W-1:0]  eff_hdr_r, eff_hdr_nxt;
  logic [IDX_W-1:0]  eff_body_r, eff_body_nxt;
  logic [CMP_W-1:0]  body_ext;
  logic [CMP_W-1:0]  hdr_ext;
  logic [CMP_W-1:0]  body_clamp;

  assign cfg_ready = 1'b1;

  // Register writes
  always_comb begin
    sync_nxt  = sync_r;
    group_nxt = group_r;
    hdr_nxt   = hdr_r;
    body_nxt  = body_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC:  sync_nxt  = cfg_data[7:0];
        CFG_GROUP: group_nxt = cfg_data[7:0];
        CFG_HDR:   hdr_nxt   = cfg_data[HDR_W-1:0];
        CFG_BODY:  body_nxt  = cfg_data;
        default:   sync_nxt  = sync_r;
      endcase
    end
  end

  // Clamp header count and body length
  always_comb begin
    if (hdr_r < HDR_MIN) begin
      eff_hdr_nxt = HDR_MIN;
    end else if (hdr_r > HDR_MAX) begin
      eff_hdr_nxt = HDR_MAX;
    end else begin
      eff_hdr_nxt = hdr_r;
    end
    body_ext = CMP_W'(body_r);
    hdr_ext  = CMP_W'(eff_hdr_nxt);
    if (body_ext < hdr_ext) begin
      body_clamp = hdr_ext;
    end else if (body_ext > CMP_W'(MAX_BODY)) begin
      body_clamp = CMP_W'(MAX_BODY);
    end else begin
      body_clamp = body_ext;
    end
    eff_body_nxt = body_clamp[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_RST;
      group_r    <= GROUP_RST;
      hdr_r      <= HDR_RST;
      body_r     <= BODY_RST;
      eff_hdr_r  <= HDR_RST;
      eff_body_r <= IDX_W'(BODY_RST);
    end else begin
      sync_r     <= sync_nxt;
      group_r    <= group_nxt;
      hdr_r      <= hdr_nxt;
      body_r     <= body_nxt;
      eff_hdr_r  <= eff_hdr_nxt;
      eff_body_r <= eff_body_nxt;
    end
  end

  assign cfg_o.sync_value  = sync_r;
  assign cfg_o.group_value = group_r;
  assign cfg_o.eff_header  = eff_hdr_r;
  assign eff_body_o        = eff_body_r;

endmodule

`default_nettype wire

// File: design/sync_header_frame_parser_crc16.sv
// Datapath: a byte is registered on input and parsed from that register when the
//   output advances; parsing the last CRC byte registers the frame's result on out_*.
// Throughput: one byte per cycle; input stalls only while a result waits.
// Reset (rst_n low, synchronous): parser returns to sync hunt, CRC and counters
//   clear, configuration returns to defaults. Limits are clamped and registered.
`default_nettype none

module sync_header_frame_parser_crc16 #(
  parameter int unsigned MAX_BODY = shfp_pkg::MAX_BODY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [15:0] computed_crc, [31:16] received_crc, [47:32] good_frames,
  //            [63:48] header_errors, [79:64] crc_errors
  // out_tuser: [0] frame_ok
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import shfp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BODY + 2);

  shfp_cfg_t         cfg;
  logic [IDX_W-1:0]  eff_body;

  shfp_cfg #(
    .MAX_BODY (MAX_BODY),
    .IDX_W    (IDX_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_o      (cfg),
    .eff_body_o (eff_body)
  );

  // Pipeline control
  logic       advance;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       step;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
      s1_byte_nxt  = in_tdata;
    end
  end

  // Parser state
  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [CRC_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  herr_r, herr_nxt;
  logic [CNT_W-1:0]  cerr_r, cerr_nxt;

  // Result register
  logic              ov_r, ov_nxt;
  logic [79:0]       od_r, od_nxt;
  logic              ook_r, ook_nxt;

  logic [IDX_W-1:0]  idx_inc;
  logic [CRC_W-1:0]  crc_upd;
  logic [CRC_W-1:0]  rec;
  logic              ok;

  assign idx_inc = idx_r + IDX_W'(1);
  assign crc_upd = crc_byte(crc_r, s1_byte_r);
  assign rec     = {cap_r[15:8], s1_byte_r};
  assign ok      = (rec == crc_r);

  // Byte parsing
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    cap_nxt   = cap_r;
    good_nxt  = good_r;
    herr_nxt  = herr_r;
    cerr_nxt  = cerr_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ook_nxt   = ook_r;
    if (advance) begin
      ov_nxt = 1'b0;
    end
    if (step) begin
      unique case (phase_r)
        PH_SYNC: begin
          idx_nxt = '0;
          if (s1_byte_r == cfg.sync_value) begin
            phase_nxt = PH_GROUP;
          end else begin
            herr_nxt = herr_r + CNT_W'(1);
          end
        end
        PH_GROUP: begin
          if (s1_byte_r == cfg.group_value) begin
            crc_nxt   = crc_byte(16'h0000, s1_byte_r);
            idx_nxt   = IDX_W'(1);
            phase_nxt = PH_HEADER;
          end else begin
            herr_nxt  = herr_r + CNT_W'(1);
            phase_nxt = PH_SYNC;
          end
        end
        PH_HEADER: begin
          crc_nxt = crc_upd;
          idx_nxt = idx_inc;
          if (idx_inc >= IDX_W'(cfg.eff_header)) begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (idx_r < eff_body) begin
            crc_nxt = crc_upd;
            idx_nxt = idx_inc;
          end else if (idx_r == eff_body) begin
            cap_nxt = {s1_byte_r, 8'h00};
            idx_nxt = idx_inc;
          end else begin
            // Low CRC byte: frame complete
            if (ok) begin
              good_nxt = good_r + CNT_W'(1);
            end else begin
              cerr_nxt = cerr_r + CNT_W'(1);
            end
            ov_nxt    = 1'b1;
            ook_nxt   = ok;
            od_nxt    = {cerr_nxt, herr_r, good_nxt, rec, crc_r};
            phase_nxt = PH_SYNC;
            idx_nxt   = '0;
          end
        end
        default: phase_nxt = PH_SYNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_SYNC;
      idx_r      <= '0;
      crc_r      <= '0;
      cap_r      <= '0;
      good_r     <= '0;
      herr_r     <= '0;
      cerr_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      crc_r      <= crc_nxt;
      cap_r      <= cap_nxt;
      good_r     <= good_nxt;
      herr_r     <= herr_nxt;
      cerr_r     <= cerr_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    od_r      <= od_nxt;
    ook_r     <= ook_nxt;
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tuser[0] = ook_r;

endmodule

`default_nettype wire

// File: design/shfp_checker.sv
`default_nettype none

module shfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not empty after reset");

  // Input only backs up behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // Pass flag agrees with the two CRCs
  a_pass_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] == (out_tdata[15:0] == out_tdata[31:16]))
    else $error("frame_ok does not match CRC comparison");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind sync_header_frame_parser_crc16 shfp_checker u_shfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: verif/sync_header_frame_parser_crc16_tb.sv
`timescale 1ns / 1ps

module sync_header_frame_parser_crc16_tb;
  import shfp_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;

  typedef logic [7:0] byte_q_t[$];

  // Per-frame summary the parser reports at the end of a frame
  typedef struct {
    logic        ok;
    logic [15:0] crc_calc;
    logic [15:0] crc_rx;
    logic [15:0] good;
    logic [15:0] hdr_err;
    logic [15:0] crc_err;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;          // computed, received, good, hdr errors, crc errors
  logic [0:0]  out_tuser;          // [0] frame_ok
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_SYNC;
  logic [9:0]  cfg_data = 10'd0;

  sync_header_frame_parser_crc16 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Traffic shaping
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int stall_left     = 0;

  // Byte stream waiting to go out, and the frame reports still owed
  logic [7:0]    line_bytes[$];
  int            queued_bytes = 0;
  frame_report_t frame_reports_due[$];

  // Handshake flags sampled mid-cycle, valid for the next rising edge
  bit in_fire, out_fire, cfg_fire;
  int quiet_cycles = 0;
  int error_count  = 0;

  // Shadow of the configuration registers
  logic [7:0] sync_reg  = SYNC_RST;
  logic [7:0] group_reg = GROUP_RST;
  logic [4:0] hdr_reg   = HDR_RST;
  logic [9:0] body_reg  = BODY_RST;

  // Shadow parser state
  phase_t      rx_phase    = PH_SYNC;
  int          byte_idx    = 0;
  logic [15:0] run_crc     = 16'h0000;
  logic [15:0] crc_hi      = 16'h0000;
  logic [15:0] good_cnt    = 16'h0000;
  logic [15:0] hdr_err_cnt = 16'h0000;
  logic [15:0] crc_err_cnt = 16'h0000;

  // CRC-16-CCITT, poly 0x1021, MSB first, bit-serial
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int header_limit();
    if (hdr_reg < HDR_MIN) return HDR_MIN;
    if (hdr_reg > HDR_MAX) return HDR_MAX;
    return hdr_reg;
  endfunction

  function automatic int body_limit();
    int h;
    int b;
    h = header_limit();
    b = body_reg;
    if (b < h) b = h;
    if (b > MAX_BODY_DEF) b = MAX_BODY_DEF;
    return b;
  endfunction

  // Advance the shadow parser by one accepted byte
  function automatic void track_rx_byte(input logic [7:0] b);
    frame_report_t rpt;
    logic [15:0]   rx_crc;
    int            limit;
    case (rx_phase)
      PH_SYNC: begin
        byte_idx = 0;
        if (b == sync_reg) rx_phase = PH_GROUP;
        else hdr_err_cnt++;
      end
      PH_GROUP: begin
        if (b == group_reg) begin
          run_crc  = crc16_next(16'h0000, b);
          byte_idx = 1;
          rx_phase = PH_HEADER;
        end else begin
          hdr_err_cnt++;
          rx_phase = PH_SYNC;
        end
      end
      PH_HEADER: begin
        run_crc = crc16_next(run_crc, b);
        byte_idx++;
        if (byte_idx >= header_limit()) rx_phase = PH_BODY;
      end
      default: begin
        limit = body_limit();
        if (byte_idx < limit) begin
          run_crc = crc16_next(run_crc, b);
          byte_idx++;
        end else if (byte_idx == limit) begin
          crc_hi = {b, 8'h00};
          byte_idx++;
        end else begin
          // low CRC byte closes the frame
          rx_crc = crc_hi | {8'h00, b};
          rpt.ok = (rx_crc == run_crc);
          if (rpt.ok) good_cnt++;
          else crc_err_cnt++;
          rpt.crc_calc = run_crc;
          rpt.crc_rx   = rx_crc;
          rpt.good     = good_cnt;
          rpt.hdr_err  = hdr_err_cnt;
          rpt.crc_err  = crc_err_cnt;
          frame_reports_due.push_back(rpt);
          rx_phase = PH_SYNC;
          byte_idx = 0;
        end
      end
    endcase
  endfunction

  // Byte source: at most one NBA per edge on in_tvalid
  always @(posedge clk) begin
    if (in_fire) track_rx_byte(in_tdata);
    if (!in_tvalid || in_fire) begin
      if (line_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= line_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Report sink: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Sample handshakes between edges, score reports, watch for a hang
  always @(negedge clk) begin : monitor
    frame_report_t want;
    in_fire  = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    cfg_fire = cfg_valid && cfg_ready;
    if (out_fire) begin
      if (frame_reports_due.size() == 0) begin
        $display("%0t: unexpected frame report, expected none, actual tuser %b tdata %h",
                 $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = frame_reports_due.pop_front();
        check_field("frame_ok", {15'd0, want.ok}, {15'd0, out_tuser[0]});
        check_field("computed_crc", want.crc_calc, out_tdata[15:0]);
        check_field("received_crc", want.crc_rx, out_tdata[31:16]);
        check_field("good_frames", want.good, out_tdata[47:32]);
        check_field("header_errors", want.hdr_err, out_tdata[63:48]);
        check_field("crc_errors", want.crc_err, out_tdata[79:64]);
      end
    end
    if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void queue_byte(input logic [7:0] b);
    line_bytes.push_back(b);
    queued_bytes++;
  endfunction

  function automatic byte_q_t random_content(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // Sync, group, content, then CRC high byte first
  task automatic push_frame(input byte_q_t content, input bit bad_crc);
    logic [15:0] crc;
    crc = crc16_next(16'h0000, group_reg);
    queue_byte(sync_reg);
    queue_byte(group_reg);
    foreach (content[i]) begin
      queue_byte(content[i]);
      crc = crc16_next(crc, content[i]);
    end
    if (bad_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
    queue_byte(crc[15:8]);
    queue_byte(crc[7:0]);
  endtask

  task automatic set_traffic(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Drain the stream and let in-flight bytes settle
  task automatic wait_idle();
    do @(negedge clk);
    while (line_bytes.size() != 0 || in_tvalid || frame_reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back while the parser is quiet
  task automatic program_regs(input logic [9:0] sync_d, input logic [9:0] group_d,
                              input logic [9:0] hdr_d, input logic [9:0] body_d);
    cfg_idx_t   order[4] = '{CFG_SYNC, CFG_GROUP, CFG_HDR, CFG_BODY};
    logic [9:0] vals[4];
    vals = '{sync_d, group_d, hdr_d, body_d};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(negedge clk);
      while (!cfg_ready);
      @(posedge clk);
      case (order[i])
        CFG_SYNC:  sync_reg  = vals[i][7:0];
        CFG_GROUP: group_reg = vals[i][7:0];
        CFG_HDR:   hdr_reg   = vals[i][4:0];
        CFG_BODY:  body_reg  = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [9:0] h;
    logic [9:0] bl;
    h = 10'($urandom);
    h[4:0] = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 6));
    bl = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 40)) : 10'($urandom_range(2, 20));
    program_regs(10'($urandom), 10'($urandom), h, bl);
  endtask

  // Reset defaults: bad sync byte, then a sync followed by a bad group byte
  task automatic test_defaults();
    set_traffic(0, 0);
    queue_byte(~SYNC_RST);
    queue_byte(SYNC_RST);
    queue_byte(~GROUP_RST);
    wait_idle();
  endtask

  // Register extremes and clamping of header count and body length
  task automatic test_extremes();
    byte_q_t pat;
    set_traffic(12, 12);
    // header 0 acts as 2, body 0 acts as header count
    program_regs(10'h0FF, 10'h300, 10'h3E0, 10'h000);
    push_frame('{8'hFF}, 1'b0);
    push_frame('{8'h00}, 1'b1);
    // header 31 acts as 16, body below header acts as 16
    program_regs(10'h300, 10'h0FF, 10'h01F, 10'h005);
    for (int i = 0; i < body_limit() - 1; i++) pat.push_back((i % 2) ? 8'hFF : 8'h00);
    push_frame(pat, 1'b0);
    queue_byte(sync_reg);
    queue_byte(~group_reg);
    wait_idle();
  endtask

  // Shrink header and body limits while a frame is half received
  task automatic test_midframe_change();
    set_traffic(0, 0);
    program_regs(10'h0A5, 10'h05A, 10'd8, 10'd20);
    queue_byte(sync_reg);
    queue_byte(group_reg);
    repeat (5) queue_byte(8'($urandom));
    program_regs(10'h0A5, 10'h05A, 10'd3, 10'd4);
    // first byte moves into the body, second is taken as the low CRC byte
    queue_byte(8'($urandom));
    queue_byte(8'($urandom));
    wait_idle();
  endtask

  // Long receiver hold-off fills the parser; then the sender drains before more
  task automatic test_backpressure();
    set_traffic(0, 0);
    program_regs(10'($urandom), 10'($urandom), 10'd2, 10'd3);
    stall_left <= HOLD_CYCLES;
    repeat (10) push_frame(random_content(body_limit() - 1), $urandom_range(0, 3) == 0);
    wait_idle();
    repeat (4) push_frame(random_content(body_limit() - 1), 1'b0);
    wait_idle();
  endtask

  // Body length above the buffer limit acts as the limit
  task automatic test_max_body();
    set_traffic(0, 20);
    program_regs(10'($urandom), 10'($urandom), 10'd16, 10'd1023);
    push_frame(random_content(body_limit() - 1), 1'b0);
    wait_idle();
  endtask

  // Mostly well-formed frames, with corrupt CRCs, noise and broken starts
  task automatic test_random_traffic();
    int src_pct[4]  = '{0, 52, 0, 12};
    int sink_pct[4] = '{0, 0, 52, 12};
    int start;
    int pick;
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 2; c++) begin
        random_config();
        set_traffic(src_pct[p], sink_pct[p]);
        start = queued_bytes;
        while (queued_bytes - start < 10) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            push_frame(random_content(body_limit() - 1), 1'b0);
          end else if (pick < 80) begin
            push_frame(random_content(body_limit() - 1), 1'b1);
          end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
          end else if (pick < 95) begin
            queue_byte(sync_reg);
            queue_byte(group_reg ^ (8'h01 << $urandom_range(0, 7)));
          end else begin
            // frame cut short; the next bytes fall into its body
            queue_byte(sync_reg);
            queue_byte(group_reg);
            repeat ($urandom_range(0, body_limit())) queue_byte(8'($urandom));
          end
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extremes();
    test_midframe_change();
    test_backpressure();
    test_max_body();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
